[rtl/core/iwc_pkg.sv]
// Shared widths, register indexes and reset values for the 3x3 window convolution unit.
package iwc_pkg;

  localparam int PIXEL_W    = 8;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = 24;
  localparam int ROW_SUM_W  = 26;
  localparam int SUM_W      = 28;
  localparam int ROUND_W    = 29;
  localparam int BYTE_W     = 8;
  localparam int DIM_W      = 11;
  localparam int ROW_BITS_W = 48;
  localparam int MASK_N     = 3;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FLIP_MODE    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_TOP     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_MID     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_BOT     = 3'd5;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MIN_DIM        = 3;

  localparam logic [DIM_W-1:0]      WIDTH_RESET  = 11'd1024;
  localparam logic [DIM_W-1:0]      HEIGHT_RESET = 11'd1024;
  localparam logic                  FLIP_RESET   = 1'b1;
  localparam logic [ROW_BITS_W-1:0] COEF_RESET   = 48'd1954239938015;

  localparam logic signed [ROUND_W-1:0] ROUND_HALF   = 29'sd2048;
  localparam logic signed [SUM_W-1:0]   SAT_HI_SUM   = 28'sd1046528;
  localparam logic [BYTE_W-1:0]         BYTE_MAX     = 8'd255;

  typedef struct packed {
    logic centre_valid;
    logic frame_end;
  } tag_t;

endpackage

[rtl/core/iwc_if.sv]
// Valid/ready stream interfaces for the pixel input and the filtered result output.
interface iwc_in_if;
  logic                         valid;
  logic                         ready;
  logic [iwc_pkg::PIXEL_W-1:0]  pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface iwc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              centre_valid;
  logic [iwc_pkg::BYTE_W-1:0]        filtered_byte;
  logic signed [iwc_pkg::SUM_W-1:0]  raw_sum;
  logic                              frame_end;
  modport source (output valid, output centre_valid, output filtered_byte, output raw_sum,
                  output frame_end, input ready);
  modport sink (input valid, input centre_valid, input filtered_byte, input raw_sum,
                input frame_end, output ready);
endinterface

[rtl/core/image_window_convolution_unit.sv]
// 3x3 window convolution over a raster pixel stream: top level with line stores and MAC pipeline.
//
// Accepts one 8-bit pixel per clock and returns one result per pixel, for the window centred
// one row and one column behind it. The rate is set by the two line-store memories, each read
// once per pixel when the pixel is taken and written back once when it leaves the read stage,
// always at different entries. Nine parallel Q4.12 multiplies, a row-sum stage and a final
// sum/round/saturate stage follow. The whole pipeline holds only while the output
// register is full and out_ch.ready is low.
// Border centres come out with centre_valid low and zero sums. Write configuration while idle.
module image_window_convolution_unit #(
  parameter int MAX_WIDTH  = iwc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = iwc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  iwc_in_if.sink                            in_ch,
  iwc_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [iwc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [iwc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int PW = iwc_pkg::PIXEL_W;
  localparam int KW = iwc_pkg::COEF_W;
  localparam int N  = iwc_pkg::MASK_N;

  // configuration
  logic [iwc_pkg::DIM_W-1:0]      width_r, height_r;
  logic                           flip_r;
  logic [iwc_pkg::ROW_BITS_W-1:0] coef_r [N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= iwc_pkg::WIDTH_RESET;
      height_r <= iwc_pkg::HEIGHT_RESET;
      flip_r   <= iwc_pkg::FLIP_RESET;
      coef_r[0] <= iwc_pkg::COEF_RESET;
      coef_r[1] <= iwc_pkg::COEF_RESET;
      coef_r[2] <= iwc_pkg::COEF_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        iwc_pkg::REG_IMAGE_WIDTH:  width_r   <= cfg_wdata[iwc_pkg::DIM_W-1:0];
        iwc_pkg::REG_IMAGE_HEIGHT: height_r  <= cfg_wdata[iwc_pkg::DIM_W-1:0];
        iwc_pkg::REG_FLIP_MODE:    flip_r    <= cfg_wdata[0];
        iwc_pkg::REG_COEF_TOP:     coef_r[0] <= cfg_wdata[iwc_pkg::ROW_BITS_W-1:0];
        iwc_pkg::REG_COEF_MID:     coef_r[1] <= cfg_wdata[iwc_pkg::ROW_BITS_W-1:0];
        iwc_pkg::REG_COEF_BOT:     coef_r[2] <= cfg_wdata[iwc_pkg::ROW_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [CW:0] w_lim, w_last;
  logic [RW:0] h_lim, h_last;

  always_comb begin
    if (32'(width_r) < 32'(iwc_pkg::MIN_DIM)) begin
      w_lim = (CW+1)'(iwc_pkg::MIN_DIM);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_lim = (CW+1)'(MAX_WIDTH);
    end else begin
      w_lim = (CW+1)'(width_r);
    end
    if (32'(height_r) < 32'(iwc_pkg::MIN_DIM)) begin
      h_lim = (RW+1)'(iwc_pkg::MIN_DIM);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_lim = (RW+1)'(MAX_HEIGHT);
    end else begin
      h_lim = (RW+1)'(height_r);
    end
    w_last = w_lim - (CW+1)'(1);
    h_last = h_lim - (RW+1)'(1);
  end

  // handshake
  logic out_valid_r;
  logic adv, in_acc;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_acc      = in_ch.valid && adv;

  // position counters
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          last_col, s0_frame_end, s0_centre;

  always_comb begin
    last_col     = {1'b0, col_r} >= w_last;
    s0_frame_end = last_col && ({1'b0, row_r} >= h_last);
    s0_centre    = (32'(row_r) >= 32'd2) && (32'(col_r) >= 32'd2) &&
                   ({1'b0, row_r} < h_lim) && ({1'b0, col_r} < w_lim);
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = s0_frame_end ? '0 : row_r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line stores
  logic [PW-1:0] upper_mem [MAX_WIDTH];
  logic [PW-1:0] lower_mem [MAX_WIDTH];
  logic [PW-1:0] top_rd_r, mid_rd_r;
  logic          s1_valid_r;
  iwc_pkg::tag_t s1_tag_r;
  logic [CW-1:0] s1_idx_r;
  logic [PW-1:0] s1_px_r;
  logic          wr_en;

  assign wr_en = s1_valid_r && adv;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[s1_idx_r] <= mid_rd_r;
      lower_mem[s1_idx_r] <= s1_px_r;
    end
    if (in_acc) begin
      top_rd_r <= upper_mem[col_r];
      mid_rd_r <= lower_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_tag_r <= '{centre_valid: s0_centre, frame_end: s0_frame_end};
      s1_idx_r <= col_r;
      s1_px_r  <= in_ch.pixel;
    end
  end

  // window columns
  logic [PW-1:0] win_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (wr_en) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_rd_r;
      win_r[4] <= mid_rd_r;
      win_r[5] <= s1_px_r;
    end
  end

  // multiply stage
  logic [PW-1:0]                      pix [N][N];
  logic signed [iwc_pkg::PROD_W-1:0]  prod_nxt [N][N];
  logic signed [iwc_pkg::PROD_W-1:0]  prod_r [N][N];
  logic                               s2_valid_r;
  iwc_pkg::tag_t                      s2_tag_r;

  always_comb begin
    logic signed [KW-1:0]              k;
    logic signed [iwc_pkg::PROD_W-1:0] ke, pe;
    pix[0][0] = win_r[0]; pix[1][0] = win_r[1]; pix[2][0] = win_r[2];
    pix[0][1] = win_r[3]; pix[1][1] = win_r[4]; pix[2][1] = win_r[5];
    pix[0][2] = top_rd_r; pix[1][2] = mid_rd_r; pix[2][2] = s1_px_r;
    for (int v = 0; v < N; v++) begin
      for (int u = 0; u < N; u++) begin
        if (flip_r) begin
          k = $signed(coef_r[N-1-v][KW*(N-1-u) +: KW]);
        end else begin
          k = $signed(coef_r[v][KW*u +: KW]);
        end
        ke = iwc_pkg::PROD_W'(k);
        pe = $signed({{(iwc_pkg::PROD_W-PW){1'b0}}, pix[v][u]});
        prod_nxt[v][u] = s1_tag_r.centre_valid ? ke * pe : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prod_r   <= prod_nxt;
      s2_tag_r <= s1_tag_r;
    end
  end

  // row sums
  logic signed [iwc_pkg::ROW_SUM_W-1:0] rsum_r [N];
  logic                                 s3_valid_r;
  iwc_pkg::tag_t                        s3_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      for (int v = 0; v < N; v++) begin
        rsum_r[v] <= iwc_pkg::ROW_SUM_W'(prod_r[v][0]) + iwc_pkg::ROW_SUM_W'(prod_r[v][1]) +
                     iwc_pkg::ROW_SUM_W'(prod_r[v][2]);
      end
      s3_tag_r <= s2_tag_r;
    end
  end

  // final sum, round and saturate
  logic signed [iwc_pkg::SUM_W-1:0]   sum_nxt;
  logic signed [iwc_pkg::ROUND_W-1:0] rnd;
  logic [iwc_pkg::BYTE_W-1:0]         byte_nxt;
  logic signed [iwc_pkg::SUM_W-1:0]   sum_r;
  logic [iwc_pkg::BYTE_W-1:0]         byte_r;
  iwc_pkg::tag_t                      out_tag_r;

  always_comb begin
    sum_nxt = iwc_pkg::SUM_W'(rsum_r[0]) + iwc_pkg::SUM_W'(rsum_r[1]) +
              iwc_pkg::SUM_W'(rsum_r[2]);
    rnd = iwc_pkg::ROUND_W'(sum_nxt) + iwc_pkg::ROUND_HALF;
    if (rnd[iwc_pkg::ROUND_W-1]) begin
      byte_nxt = '0;
    end else if (|rnd[iwc_pkg::ROUND_W-2:20]) begin
      byte_nxt = iwc_pkg::BYTE_MAX;
    end else begin
      byte_nxt = rnd[19:12];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid_r) begin
      sum_r     <= sum_nxt;
      byte_r    <= byte_nxt;
      out_tag_r <= s3_tag_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.centre_valid  = out_tag_r.centre_valid;
  assign out_ch.filtered_byte = byte_r;
  assign out_ch.raw_sum       = sum_r;
  assign out_ch.frame_end     = out_tag_r.frame_end;

`ifndef SYNTHESIS
  a_rw_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && in_acc) |-> (s1_idx_r != col_r))
    else $error("line store read and write-back hit the same entry");

  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s0_frame_end) |=> (col_r == '0 && row_r == '0))
    else $error("counters did not wrap after frame end");

  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tag_r.centre_valid) |-> (sum_r == '0 && byte_r == '0))
    else $error("border result carries nonzero data");

  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && sum_r >= iwc_pkg::SAT_HI_SUM) |-> (byte_r == iwc_pkg::BYTE_MAX))
    else $error("large sum did not saturate");
`endif

endmodule
